// ===== design/thw_pkg.sv =====
// ----------------------------------------------------------------------------
// thw_pkg
// Shared widths, register codes, payload structs and fixed-point helpers for
// the tapered Hann window weight pipeline.
// ----------------------------------------------------------------------------
package thw_pkg;

	// field widths
	localparam int SIZE_W     = 13;
	localparam int ALPHA_W    = 17;
	localparam int IDX_W      = 12;
	localparam int WEIGHT_W   = 18;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 17;

	localparam int MAX_SIZE         = 4096;
	localparam int WEIGHT_FRAC_BITS = 16;
	localparam int ALPHA_ONE        = 65536;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ALPHA       = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FLAT_LENGTH = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_RISE_LENGTH = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_FALL_LENGTH = 3'd4;

	// phase and divider geometry
	localparam int PH_BITS   = 24;
	localparam int QUOT_W    = PH_BITS + 1;
	localparam int DIV_W     = 12;
	localparam int NUM_W     = IDX_W + PH_BITS;
	localparam int DIV_STEPS = QUOT_W;

	localparam int QUARTER_TURN = 1 << (PH_BITS - 2);
	localparam int EIGHTH_TURN  = 1 << (PH_BITS - 3);

	// cosine arithmetic, Q30
	localparam int Q_W                 = 30;
	localparam logic [32:0] TWO_PI_Q30 = 33'd6746518852;
	localparam logic [Q_W:0] ONE_Q30   = 31'h4000_0000;
	localparam int TERMS               = 5;
	localparam int TERM_IDX_W          = 3;

	// exact floor division by the Taylor denominators: (p * M) >> K, p < 2^30
	localparam logic [63:0] RCP_2       = ((64'd1 << 31) + 64'd2 - 64'd1) / 64'd2;
	localparam logic [63:0] RCP_24      = ((64'd1 << 35) + 64'd24 - 64'd1) / 64'd24;
	localparam logic [63:0] RCP_720     = ((64'd1 << 40) + 64'd720 - 64'd1) / 64'd720;
	localparam logic [63:0] RCP_40320   = ((64'd1 << 46) + 64'd40320 - 64'd1) / 64'd40320;
	localparam logic [63:0] RCP_3628800 = ((64'd1 << 52) + 64'd3628800 - 64'd1) / 64'd3628800;
	localparam logic [63:0] RCP_6       = ((64'd1 << 33) + 64'd6 - 64'd1) / 64'd6;
	localparam logic [63:0] RCP_120     = ((64'd1 << 37) + 64'd120 - 64'd1) / 64'd120;
	localparam logic [63:0] RCP_5040    = ((64'd1 << 43) + 64'd5040 - 64'd1) / 64'd5040;
	localparam logic [63:0] RCP_362880  = ((64'd1 << 49) + 64'd362880 - 64'd1) / 64'd362880;

	typedef struct packed {
		logic [SIZE_W-1:0]  window_size;
		logic [ALPHA_W-1:0] alpha;
		logic [SIZE_W-1:0]  flat_length;
		logic [SIZE_W-1:0]  rise_length;
		logic [SIZE_W-1:0]  fall_length;
	} cfg_t;

	// request to the phase divider
	typedef struct packed {
		logic [NUM_W-1:0] num;
		logic [DIV_W-1:0] den;
		logic             off;
		logic             one;
		logic             err;
	} div_req_t;

	// one step of the phase divider
	typedef struct packed {
		logic [DIV_W-1:0]  rem;
		logic [NUM_W-1:0]  num;
		logic [DIV_W-1:0]  den;
		logic [QUOT_W-1:0] quo;
		logic              off;
		logic              one;
		logic              err;
	} div_stage_t;

	// phase in turns from the divider
	typedef struct packed {
		logic [QUOT_W-1:0] quo;
		logic              off;
		logic              one;
		logic              err;
	} phase_t;

	// clamped cosine, Q30
	typedef struct packed {
		logic signed [31:0] cosv;
		logic               one;
		logic               err;
	} cos_res_t;

	// rounded Q30 product
	function automatic logic [Q_W-1:0] mul_q30(input logic [Q_W:0] a, input logic [Q_W-1:0] b);
		logic [2*Q_W:0] prod;
		prod = (2*Q_W+1)'(a) * (2*Q_W+1)'(b) + (2*Q_W+1)'(ONE_Q30 >> 1);
		return prod[2*Q_W-1:Q_W];
	endfunction

	// reciprocal multiplier for term k of the cosine or sine series
	function automatic logic [31:0] rcp_mult(input logic cos_mode, input logic [TERM_IDX_W-1:0] k);
		logic [63:0] m;
		m = '0;
		if (cos_mode) begin
			case (k)
				3'd0: m = RCP_2;
				3'd1: m = RCP_24;
				3'd2: m = RCP_720;
				3'd3: m = RCP_40320;
				3'd4: m = RCP_3628800;
				default: m = '0;
			endcase
		end else begin
			case (k)
				3'd0: m = RCP_6;
				3'd1: m = RCP_120;
				3'd2: m = RCP_5040;
				3'd3: m = RCP_362880;
				default: m = '0;
			endcase
		end
		return m[31:0];
	endfunction

	// matching right shift
	function automatic logic [5:0] rcp_shift(input logic cos_mode, input logic [TERM_IDX_W-1:0] k);
		logic [5:0] s;
		s = 6'd31;
		if (cos_mode) begin
			case (k)
				3'd0: s = 6'd31;
				3'd1: s = 6'd35;
				3'd2: s = 6'd40;
				3'd3: s = 6'd46;
				3'd4: s = 6'd52;
				default: s = 6'd31;
			endcase
		end else begin
			case (k)
				3'd0: s = 6'd33;
				3'd1: s = 6'd37;
				3'd2: s = 6'd43;
				3'd3: s = 6'd49;
				default: s = 6'd31;
			endcase
		end
		return s;
	endfunction

endpackage

// ===== design/thw_cfg_if.sv =====
// ----------------------------------------------------------------------------
// thw_cfg_if
// Register write channel: valid, ready, register index and write data.
// ----------------------------------------------------------------------------
interface thw_cfg_if;
	logic                                valid;
	logic                                ready;
	logic [thw_pkg::CFG_IDX_W-1:0]       index;
	logic [thw_pkg::CFG_DATA_W-1:0]      data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

// ===== design/thw_in_if.sv =====
// ----------------------------------------------------------------------------
// thw_in_if
// Sample index request channel.
// ----------------------------------------------------------------------------
interface thw_in_if;
	logic                          valid;
	logic                          ready;
	logic [thw_pkg::IDX_W-1:0]     sample_index;

	modport source(output valid, sample_index, input ready);
	modport sink(input valid, sample_index, output ready);
endinterface

// ===== design/thw_out_if.sv =====
// ----------------------------------------------------------------------------
// thw_out_if
// Window weight result channel.
// ----------------------------------------------------------------------------
interface thw_out_if;
	logic                                valid;
	logic                                ready;
	logic signed [thw_pkg::WEIGHT_W-1:0] weight;
	logic                                index_error;

	modport source(output valid, weight, index_error, input ready);
	modport sink(input valid, weight, index_error, output ready);
endinterface

// ===== design/thw_front.sv =====
// ----------------------------------------------------------------------------
// thw_front
// Resolves the window segments, picks the segment of the index and forms the
// phase numerator and denominator. Three pipeline stages.
// ----------------------------------------------------------------------------
module thw_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  thw_pkg::cfg_t                  cfg,
	input  logic                           i_valid,
	output logic                           i_ready,
	input  logic [thw_pkg::IDX_W-1:0]      i_index,
	output logic                           o_valid,
	input  logic                           o_ready,
	output thw_pkg::div_req_t              o_req
);

	localparam int NST = 3;

	logic [NST-1:0] vld_q;
	logic [NST:0]   en;

	// stall chain, a bubble absorbs a stall
	always_comb begin
		en[NST] = o_ready;
		for (int k = NST - 1; k >= 0; k--) begin
			en[k] = !vld_q[k] || en[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			for (int k = 0; k < NST; k++) begin
				if (en[k]) begin
					vld_q[k] <= (k == 0) ? i_valid : vld_q[k-1];
				end
			end
		end
	end

	assign i_ready = en[0];
	assign o_valid = vld_q[NST-1];

	// stage 1: effective size and segment lengths
	logic [thw_pkg::SIZE_W-1:0] size_c, rise_c, fall_c, half_c, szmf_c;
	logic [thw_pkg::SIZE_W+1:0] sum_c;
	logic                        over_c, full_c;

	always_comb begin
		size_c = (cfg.window_size > thw_pkg::SIZE_W'(thw_pkg::MAX_SIZE)) ?
			thw_pkg::SIZE_W'(thw_pkg::MAX_SIZE) : cfg.window_size;
		sum_c  = (thw_pkg::SIZE_W+2)'(cfg.flat_length) + (thw_pkg::SIZE_W+2)'(cfg.rise_length)
			+ (thw_pkg::SIZE_W+2)'(cfg.fall_length);
		over_c = sum_c > (thw_pkg::SIZE_W+2)'(size_c);
		half_c = (size_c - cfg.flat_length) >> 1;
		if (over_c) begin
			full_c = (cfg.flat_length > size_c) || (cfg.flat_length == '0);
			if (cfg.flat_length == size_c) begin
				rise_c = '0;
				fall_c = '0;
			end else begin
				rise_c = half_c;
				fall_c = half_c;
			end
		end else begin
			full_c = (cfg.flat_length == '0);
			rise_c = cfg.rise_length;
			fall_c = cfg.fall_length;
		end
		szmf_c = size_c - fall_c;
	end

	logic [thw_pkg::IDX_W-1:0]  idx_s1;
	logic [thw_pkg::SIZE_W-1:0] size_s1, rise_s1, fall_s1, szmf_s1;
	logic                        full_s1;

	always_ff @(posedge clk) begin
		if (en[0]) begin
			idx_s1  <= i_index;
			size_s1 <= size_c;
			rise_s1 <= rise_c;
			fall_s1 <= fall_c;
			szmf_s1 <= szmf_c;
			full_s1 <= full_c;
		end
	end

	// stage 2: segment select
	logic [thw_pkg::SIZE_W-1:0] idx_x, m_c, len_c;
	logic [thw_pkg::IDX_W-1:0]  n_c;
	logic                        err_c, one_c, off_c, sh24_c;

	always_comb begin
		idx_x  = {1'b0, idx_s1};
		m_c    = idx_x - szmf_s1;
		err_c  = idx_x >= size_s1;
		n_c    = '0;
		len_c  = '0;
		off_c  = 1'b0;
		sh24_c = 1'b0;
		one_c  = 1'b1;
		if (full_s1) begin
			n_c    = idx_s1;
			len_c  = size_s1;
			sh24_c = 1'b1;
			one_c  = size_s1 < thw_pkg::SIZE_W'(2);
		end else if (idx_x < rise_s1) begin
			n_c   = idx_s1;
			len_c = rise_s1;
			one_c = rise_s1 < thw_pkg::SIZE_W'(2);
		end else if (idx_x >= szmf_s1) begin
			n_c   = m_c[thw_pkg::IDX_W-1:0];
			len_c = fall_s1;
			off_c = 1'b1;
			one_c = fall_s1 < thw_pkg::SIZE_W'(2);
		end
	end

	logic [thw_pkg::IDX_W-1:0]  n_s2;
	logic [thw_pkg::SIZE_W-1:0] len_s2;
	logic                        err_s2, one_s2, off_s2, sh24_s2;

	always_ff @(posedge clk) begin
		if (en[1]) begin
			n_s2    <= n_c;
			len_s2  <= len_c;
			err_s2  <= err_c;
			one_s2  <= one_c;
			off_s2  <= off_c;
			sh24_s2 <= sh24_c;
		end
	end

	// stage 3: numerator n * 2^bits + d / 2
	logic [thw_pkg::SIZE_W-1:0] dfull_c;
	logic [thw_pkg::DIV_W-1:0]  den_c;
	logic [thw_pkg::NUM_W-1:0]  num_c;

	always_comb begin
		dfull_c = len_s2 - thw_pkg::SIZE_W'(1);
		den_c   = dfull_c[thw_pkg::DIV_W-1:0];
		num_c   = (sh24_s2 ? {n_s2, {thw_pkg::PH_BITS{1'b0}}}
			: {1'b0, n_s2, {(thw_pkg::PH_BITS-1){1'b0}}})
			+ thw_pkg::NUM_W'(den_c >> 1);
	end

	thw_pkg::div_req_t req_s3;

	always_ff @(posedge clk) begin
		if (en[2]) begin
			req_s3.num <= num_c;
			req_s3.den <= den_c;
			req_s3.off <= off_s2;
			req_s3.one <= one_s2;
			req_s3.err <= err_s2;
		end
	end

	assign o_req = req_s3;

endmodule

// ===== design/thw_div.sv =====
// ----------------------------------------------------------------------------
// thw_div
// Pipelined restoring divider for the phase: one quotient bit per stage.
// ----------------------------------------------------------------------------
module thw_div (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               i_valid,
	output logic               i_ready,
	input  thw_pkg::div_req_t  i_req,
	output logic               o_valid,
	input  logic               o_ready,
	output thw_pkg::phase_t    o_ph
);

	localparam int NST = thw_pkg::DIV_STEPS;

	logic [NST-1:0] vld_q;
	logic [NST:0]   en;

	// stall chain
	always_comb begin
		en[NST] = o_ready;
		for (int k = NST - 1; k >= 0; k--) begin
			en[k] = !vld_q[k] || en[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			for (int k = 0; k < NST; k++) begin
				if (en[k]) begin
					vld_q[k] <= (k == 0) ? i_valid : vld_q[k-1];
				end
			end
		end
	end

	assign i_ready = en[0];
	assign o_valid = vld_q[NST-1];

	thw_pkg::div_stage_t stg_s [NST];

	for (genvar j = 0; j < NST; j++) begin : g_step
		localparam int BIT = thw_pkg::QUOT_W - 1 - j;

		thw_pkg::div_stage_t src, nxt;
		logic [thw_pkg::DIV_W:0] rr;
		logic                     ge;

		// source of this step
		if (j == 0) begin : g_first
			always_comb begin
				src.rem = thw_pkg::DIV_W'(i_req.num[thw_pkg::NUM_W-1:thw_pkg::QUOT_W]);
				src.num = i_req.num;
				src.den = i_req.den;
				src.quo = '0;
				src.off = i_req.off;
				src.one = i_req.one;
				src.err = i_req.err;
			end
		end else begin : g_next
			assign src = stg_s[j-1];
		end

		// compare and subtract for one quotient bit
		always_comb begin
			rr  = {src.rem, src.num[BIT]};
			ge  = rr >= {1'b0, src.den};
			nxt = src;
			nxt.rem = ge ? thw_pkg::DIV_W'(rr - {1'b0, src.den}) : thw_pkg::DIV_W'(rr);
			nxt.quo = {src.quo[thw_pkg::QUOT_W-2:0], ge};
		end

		always_ff @(posedge clk) begin
			if (en[j]) begin
				stg_s[j] <= nxt;
			end
		end
	end

	assign o_ph.quo = stg_s[NST-1].quo;
	assign o_ph.off = stg_s[NST-1].off;
	assign o_ph.one = stg_s[NST-1].one;
	assign o_ph.err = stg_s[NST-1].err;

endmodule

// ===== design/thw_cos.sv =====
// ----------------------------------------------------------------------------
// thw_cos
// Cosine of a phase in turns: quadrant and octant folding, conversion to
// radians and a pipelined Taylor series, one term per stage.
// ----------------------------------------------------------------------------
module thw_cos (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               i_valid,
	output logic               i_ready,
	input  thw_pkg::phase_t    i_ph,
	output logic               o_valid,
	input  logic               o_ready,
	output thw_pkg::cos_res_t  o_cos
);

	localparam int NST  = 6 + thw_pkg::TERMS;
	localparam int QW   = thw_pkg::Q_W;
	localparam int T0   = 4;

	logic [NST-1:0] vld_q;
	logic [NST:0]   en;

	// stall chain
	always_comb begin
		en[NST] = o_ready;
		for (int k = NST - 1; k >= 0; k--) begin
			en[k] = !vld_q[k] || en[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			for (int k = 0; k < NST; k++) begin
				if (en[k]) begin
					vld_q[k] <= (k == 0) ? i_valid : vld_q[k-1];
				end
			end
		end
	end

	assign i_ready = en[0];
	assign o_valid = vld_q[NST-1];

	// stage 1: fold into the first octant
	logic [thw_pkg::PH_BITS-1:0] ph_c;
	logic [1:0]                  quad_c;
	logic [thw_pkg::PH_BITS-2:0] a_c;
	logic [thw_pkg::PH_BITS-3:0] ang_c;
	logic                        cosm_c;

	always_comb begin
		ph_c   = i_ph.quo[thw_pkg::PH_BITS-1:0] + {i_ph.off, {(thw_pkg::PH_BITS-1){1'b0}}};
		quad_c = ph_c[thw_pkg::PH_BITS-1:thw_pkg::PH_BITS-2];
		a_c    = quad_c[0] ?
			((thw_pkg::PH_BITS-1)'(thw_pkg::QUARTER_TURN) - {1'b0, ph_c[thw_pkg::PH_BITS-3:0]})
			: {1'b0, ph_c[thw_pkg::PH_BITS-3:0]};
		cosm_c = a_c <= (thw_pkg::PH_BITS-1)'(thw_pkg::EIGHTH_TURN);
		ang_c  = cosm_c ? a_c[thw_pkg::PH_BITS-3:0]
			: (thw_pkg::PH_BITS-2)'((thw_pkg::PH_BITS-1)'(thw_pkg::QUARTER_TURN) - a_c);
	end

	logic [thw_pkg::PH_BITS-3:0] ang_s1;
	logic                        cosm_s1, neg_s1, one_s1, err_s1;

	always_ff @(posedge clk) begin
		if (en[0]) begin
			ang_s1  <= ang_c;
			cosm_s1 <= cosm_c;
			neg_s1  <= quad_c[1] ^ quad_c[0];
			one_s1  <= i_ph.one;
			err_s1  <= i_ph.err;
		end
	end

	// stage 2: turns to radians, Q30
	logic [55:0] rad_c;

	always_comb begin
		rad_c = 56'(ang_s1) * 56'(thw_pkg::TWO_PI_Q30)
			+ 56'(1 << (thw_pkg::PH_BITS - 1));
	end

	logic [QW-1:0] x_s2;
	logic          cosm_s2, neg_s2, one_s2, err_s2;

	always_ff @(posedge clk) begin
		if (en[1]) begin
			x_s2    <= rad_c[thw_pkg::PH_BITS+QW-1:thw_pkg::PH_BITS];
			cosm_s2 <= cosm_s1;
			neg_s2  <= neg_s1;
			one_s2  <= one_s1;
			err_s2  <= err_s1;
		end
	end

	// stage 3: x squared
	logic [QW-1:0] x_s3, x2_s3;
	logic          cosm_s3, neg_s3, one_s3, err_s3;

	always_ff @(posedge clk) begin
		if (en[2]) begin
			x_s3    <= x_s2;
			x2_s3   <= thw_pkg::mul_q30({1'b0, x_s2}, x_s2);
			cosm_s3 <= cosm_s2;
			neg_s3  <= neg_s2;
			one_s3  <= one_s2;
			err_s3  <= err_s2;
		end
	end

	// stage 4: first power and series start value
	logic [QW:0] base_c;

	assign base_c = cosm_s3 ? thw_pkg::ONE_Q30 : {1'b0, x_s3};

	logic [QW-1:0]      pw_s4, x2_s4;
	logic signed [31:0] sum_s4;
	logic               cosm_s4, neg_s4, one_s4, err_s4;

	always_ff @(posedge clk) begin
		if (en[3]) begin
			pw_s4   <= thw_pkg::mul_q30(base_c, x2_s3);
			x2_s4   <= x2_s3;
			sum_s4  <= signed'(32'(base_c));
			cosm_s4 <= cosm_s3;
			neg_s4  <= neg_s3;
			one_s4  <= one_s3;
			err_s4  <= err_s3;
		end
	end

	// term stages: divide the power, form the next power, add the last term
	logic [QW-1:0]      pw_s   [thw_pkg::TERMS];
	logic [QW-1:0]      trm_s  [thw_pkg::TERMS];
	logic [QW-1:0]      x2_s   [thw_pkg::TERMS];
	logic signed [31:0] sum_s  [thw_pkg::TERMS];
	logic               cosm_s [thw_pkg::TERMS];
	logic               neg_s  [thw_pkg::TERMS];
	logic               one_s  [thw_pkg::TERMS];
	logic               err_s  [thw_pkg::TERMS];

	for (genvar k = 0; k < thw_pkg::TERMS; k++) begin : g_term
		logic [QW-1:0]      pw_in, x2_in;
		logic signed [31:0] sum_in;
		logic               cosm_in, neg_in, one_in, err_in;
		logic [61:0]        quo_c;

		if (k == 0) begin : g_first
			assign pw_in   = pw_s4;
			assign x2_in   = x2_s4;
			assign sum_in  = sum_s4;
			assign cosm_in = cosm_s4;
			assign neg_in  = neg_s4;
			assign one_in  = one_s4;
			assign err_in  = err_s4;
		end else begin : g_next
			assign pw_in   = pw_s[k-1];
			assign x2_in   = x2_s[k-1];
			assign cosm_in = cosm_s[k-1];
			assign neg_in  = neg_s[k-1];
			assign one_in  = one_s[k-1];
			assign err_in  = err_s[k-1];
			// terms alternate: even terms subtract
			if ((k - 1) % 2 == 0) begin : g_sub
				assign sum_in = sum_s[k-1] - signed'({2'b00, trm_s[k-1]});
			end else begin : g_add
				assign sum_in = sum_s[k-1] + signed'({2'b00, trm_s[k-1]});
			end
		end

		always_comb begin
			quo_c = (62'(pw_in)
				* 62'(thw_pkg::rcp_mult(cosm_in, thw_pkg::TERM_IDX_W'(k))))
				>> thw_pkg::rcp_shift(cosm_in, thw_pkg::TERM_IDX_W'(k));
		end

		always_ff @(posedge clk) begin
			if (en[T0+k]) begin
				trm_s[k]  <= quo_c[QW-1:0];
				pw_s[k]   <= thw_pkg::mul_q30({1'b0, pw_in}, x2_in);
				x2_s[k]   <= x2_in;
				sum_s[k]  <= sum_in;
				cosm_s[k] <= cosm_in;
				neg_s[k]  <= neg_in;
				one_s[k]  <= one_in;
				err_s[k]  <= err_in;
			end
		end
	end

	// last term: even count, subtracts
	localparam int TL = thw_pkg::TERMS - 1;

	logic signed [31:0] sum_s10;
	logic               neg_s10, one_s10, err_s10;

	always_ff @(posedge clk) begin
		if (en[T0+thw_pkg::TERMS]) begin
			sum_s10 <= sum_s[TL] - signed'({2'b00, trm_s[TL]});
			neg_s10 <= neg_s[TL];
			one_s10 <= one_s[TL];
			err_s10 <= err_s[TL];
		end
	end

	// quadrant sign and clamp to +-1.0
	logic signed [31:0] sgn_c, clp_c;
	localparam logic signed [31:0] ONE_S = signed'(32'(thw_pkg::ONE_Q30));

	always_comb begin
		sgn_c = neg_s10 ? -sum_s10 : sum_s10;
		if (sgn_c > ONE_S) begin
			clp_c = ONE_S;
		end else if (sgn_c < -ONE_S) begin
			clp_c = -ONE_S;
		end else begin
			clp_c = sgn_c;
		end
	end

	thw_pkg::cos_res_t res_s11;

	always_ff @(posedge clk) begin
		if (en[NST-1]) begin
			res_s11.cosv <= clp_c;
			res_s11.one  <= one_s10;
			res_s11.err  <= err_s10;
		end
	end

	assign o_cos = res_s11;

endmodule

// ===== design/thw_wgt.sv =====
// ----------------------------------------------------------------------------
// thw_wgt
// Weight alpha - (1 - alpha) * cos, rounded to Q1.16 and clamped. The last
// stage is the output register of the block.
// ----------------------------------------------------------------------------
module thw_wgt (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic [thw_pkg::ALPHA_W-1:0]         alpha,
	input  logic                                i_valid,
	output logic                                i_ready,
	input  thw_pkg::cos_res_t                   i_cos,
	output logic                                o_valid,
	input  logic                                o_ready,
	output logic signed [thw_pkg::WEIGHT_W-1:0] o_weight,
	output logic                                o_error
);

	localparam int NST = 2;
	localparam int SH  = 46 - thw_pkg::WEIGHT_FRAC_BITS;
	localparam logic signed [thw_pkg::WEIGHT_W+1:0] ONE_W =
		(thw_pkg::WEIGHT_W+2)'(1 << thw_pkg::WEIGHT_FRAC_BITS);

	logic [NST-1:0] vld_q;
	logic [NST:0]   en;

	// stall chain
	always_comb begin
		en[NST] = o_ready;
		for (int k = NST - 1; k >= 0; k--) begin
			en[k] = !vld_q[k] || en[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			for (int k = 0; k < NST; k++) begin
				if (en[k]) begin
					vld_q[k] <= (k == 0) ? i_valid : vld_q[k-1];
				end
			end
		end
	end

	assign i_ready = en[0];
	assign o_valid = vld_q[NST-1];

	// stage 1: (1 - alpha) * cos
	logic [thw_pkg::ALPHA_W-1:0] asat_c, comp_c;

	always_comb begin
		asat_c = (alpha > thw_pkg::ALPHA_W'(thw_pkg::ALPHA_ONE)) ?
			thw_pkg::ALPHA_W'(thw_pkg::ALPHA_ONE) : alpha;
		comp_c = thw_pkg::ALPHA_W'(thw_pkg::ALPHA_ONE) - asat_c;
	end

	logic signed [49:0]          prod_s1;
	logic [thw_pkg::ALPHA_W-1:0] asat_s1;
	logic                        one_s1, err_s1;

	always_ff @(posedge clk) begin
		if (en[0]) begin
			prod_s1 <= signed'({1'b0, comp_c}) * i_cos.cosv;
			asat_s1 <= asat_c;
			one_s1  <= i_cos.one;
			err_s1  <= i_cos.err;
		end
	end

	// stage 2: difference, round half up, clamp
	logic signed [49:0]                   w_c;
	logic signed [49:0]                   rnd_c;
	logic signed [thw_pkg::WEIGHT_W+1:0]  r_c;
	logic signed [thw_pkg::WEIGHT_W+1:0]  sel_c;

	always_comb begin
		w_c   = signed'(50'(asat_s1) << 30) - prod_s1;
		rnd_c = (w_c + signed'(50'(1) << (SH - 1))) >>> SH;
		r_c   = rnd_c[thw_pkg::WEIGHT_W+1:0];
		if (err_s1) begin
			sel_c = '0;
		end else if (one_s1) begin
			sel_c = ONE_W;
		end else if (r_c > ONE_W) begin
			sel_c = ONE_W;
		end else if (r_c < -ONE_W) begin
			sel_c = -ONE_W;
		end else begin
			sel_c = r_c;
		end
	end

	logic signed [thw_pkg::WEIGHT_W-1:0] weight_s2;
	logic                                err_s2;

	always_ff @(posedge clk) begin
		if (en[1]) begin
			weight_s2 <= sel_c[thw_pkg::WEIGHT_W-1:0];
			err_s2    <= err_s1;
		end
	end

	assign o_weight = weight_s2;
	assign o_error  = err_s2;

endmodule

// ===== design/tapered_hann_window_weight.sv =====
// ----------------------------------------------------------------------------
// tapered_hann_window_weight
// Window weight per sample index: full generalized Hamming window, or a
// tapered window with rising half-cosine, flat top and falling half-cosine.
// ----------------------------------------------------------------------------
// One index is taken per clock while the result side does not stall, and one Q1.16
// weight comes out per index, in order through segment selection, the phase
// divider (one quotient bit per stage), cosine folding and Taylor series, and
// weighting. Each stage stalls only when it holds an item that cannot move, so
// bubbles close up under back pressure. Registers are written through the config
// channel, always ready; the user must write them only while no index is in
// flight, as the block itself does not enforce it.
module tapered_hann_window_weight (
	input  logic       clk,
	input  logic       arst_n,
	thw_cfg_if.sink    cfg,
	thw_in_if.sink     sample,
	thw_out_if.source  result
);

	// configuration registers
	logic [thw_pkg::SIZE_W-1:0]  window_size_q, flat_length_q, rise_length_q, fall_length_q;
	logic [thw_pkg::ALPHA_W-1:0] alpha_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_size_q <= thw_pkg::SIZE_W'(1024);
			alpha_q       <= thw_pkg::ALPHA_W'(32768);
			flat_length_q <= '0;
			rise_length_q <= '0;
			fall_length_q <= '0;
		end else if (cfg.valid) begin
			case (cfg.index)
				thw_pkg::REG_WINDOW_SIZE: window_size_q <= cfg.data[thw_pkg::SIZE_W-1:0];
				thw_pkg::REG_ALPHA:       alpha_q       <= cfg.data[thw_pkg::ALPHA_W-1:0];
				thw_pkg::REG_FLAT_LENGTH: flat_length_q <= cfg.data[thw_pkg::SIZE_W-1:0];
				thw_pkg::REG_RISE_LENGTH: rise_length_q <= cfg.data[thw_pkg::SIZE_W-1:0];
				thw_pkg::REG_FALL_LENGTH: fall_length_q <= cfg.data[thw_pkg::SIZE_W-1:0];
				default: ;
			endcase
		end
	end

	thw_pkg::cfg_t cfg_c;

	always_comb begin
		cfg_c.window_size = window_size_q;
		cfg_c.alpha       = alpha_q;
		cfg_c.flat_length = flat_length_q;
		cfg_c.rise_length = rise_length_q;
		cfg_c.fall_length = fall_length_q;
	end

	// pipeline segments
	logic                fr_valid, fr_ready, dv_valid, dv_ready, cs_valid, cs_ready;
	thw_pkg::div_req_t   fr_req;
	thw_pkg::phase_t     dv_ph;
	thw_pkg::cos_res_t   cs_res;

	thw_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_c),
		.i_valid (sample.valid),
		.i_ready (sample.ready),
		.i_index (sample.sample_index),
		.o_valid (fr_valid),
		.o_ready (fr_ready),
		.o_req   (fr_req)
	);

	thw_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.i_valid (fr_valid),
		.i_ready (fr_ready),
		.i_req   (fr_req),
		.o_valid (dv_valid),
		.o_ready (dv_ready),
		.o_ph    (dv_ph)
	);

	thw_cos u_cos (
		.clk     (clk),
		.arst_n  (arst_n),
		.i_valid (dv_valid),
		.i_ready (dv_ready),
		.i_ph    (dv_ph),
		.o_valid (cs_valid),
		.o_ready (cs_ready),
		.o_cos   (cs_res)
	);

	thw_wgt u_wgt (
		.clk      (clk),
		.arst_n   (arst_n),
		.alpha    (alpha_q),
		.i_valid  (cs_valid),
		.i_ready  (cs_ready),
		.i_cos    (cs_res),
		.o_valid  (result.valid),
		.o_ready  (result.ready),
		.o_weight (result.weight),
		.o_error  (result.index_error)
	);

endmodule
